// ===== rtl/poc_pkg.sv =====
// shared types, constants and helpers for the pattern occurrence counter
`timescale 1ns / 1ps
`default_nettype none

package poc_pkg;

	// capacity of the pattern store and the text window
	localparam int PATTERN_MAX = 64;
	// width of the running occurrence total
	localparam int COUNT_BITS = 16;

	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	localparam int CHAR_W = 8;
	localparam int OUT_COUNT_W = 16;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
	localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
	localparam logic [CHAR_W-1:0] UPPER_LAST = 8'h5a;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_TEXT = 2'd2;

	localparam logic [1:0] MODE_EXACT = 2'd0;
	localparam logic [1:0] MODE_FOLD = 2'd1;
	localparam logic [1:0] MODE_NOSPACE = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_TEXT,
		OP_HOLD
	} op_t;

	typedef struct packed {
		op_t op;
		logic [CHAR_W-1:0] chr;
	} entry_t;

	typedef struct packed {
		logic [OUT_COUNT_W-1:0] count;
		logic here;
		logic full;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CHECK,
		ST_DONE
	} state_t;

	function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c,
			input logic [1:0] mode);
		if (mode == MODE_FOLD && c >= UPPER_FIRST && c <= UPPER_LAST) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/poc_front.sv =====
// input side: decodes each item into an operation and holds it in a short queue
`timescale 1ns / 1ps
`default_nettype none

module poc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [1:0]        command,
	input  wire logic [7:0]        char_code,
	input  wire logic [1:0]        mode,
	output logic                   q_valid,
	output poc_pkg::entry_t        q_entry,
	input  wire logic              q_pop
);
	import poc_pkg::*;

	entry_t            ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	entry_t            decoded;
	logic              do_push;
	logic              do_pop;

	// spaces in no-space mode never reach the window, so they leave the window and the total unchanged
	always_comb begin
		decoded.chr = char_code;
		case (command)
			CMD_CLEAR:  decoded.op = OP_CLEAR;
			CMD_APPEND: decoded.op = OP_APPEND;
			CMD_TEXT: begin
				if (mode == MODE_NOSPACE && char_code == SPACE_CODE) begin
					decoded.op = OP_HOLD;
				end else begin
					decoded.op = OP_TEXT;
				end
			end
			default:    decoded.op = OP_HOLD;
		endcase
	end

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_entry = ent_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/poc_back.sv =====
// execution side: pattern and window memories, comparison walk, count and result register
`timescale 1ns / 1ps
`default_nettype none

module poc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        mode,
	input  wire logic              q_valid,
	input  wire poc_pkg::entry_t   q_entry,
	output logic                   q_pop,
	output logic                   out_valid,
	output poc_pkg::result_t       out_result,
	input  wire logic              out_pop
);
	import poc_pkg::*;

	localparam int AW = LEN_W + 1;

	logic [CHAR_W-1:0] pat_mem [PATTERN_MAX];
	logic [CHAR_W-1:0] win_mem [PATTERN_MAX];
	logic [CHAR_W-1:0] pat_rd_q;
	logic [CHAR_W-1:0] win_rd_q;

	state_t            state_q;
	state_t            state_d;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  seen_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  i_q;
	logic [LEN_W-1:0]  k_q;
	logic [COUNT_BITS-1:0] total_q;
	logic              here_q;
	logic              full_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [AW-1:0]     rd_sum;
	logic [IDX_W-1:0]  win_addr;
	logic              skip;
	logic              miss;
	logic              last;
	logic [LEN_W-1:0]  k_next;
	logic              found;
	logic              slot_free;
	logic              pat_we;
	logic              win_we;
	logic              has_room;

	// window byte k places back from the newest one
	assign rd_sum   = AW'(head_q) + AW'(PATTERN_MAX - 1) - AW'(k_q);
	assign win_addr = (rd_sum >= AW'(PATTERN_MAX)) ? IDX_W'(rd_sum - AW'(PATTERN_MAX))
	                                               : IDX_W'(rd_sum);

	assign has_room  = (len_q < LEN_W'(PATTERN_MAX));
	assign skip      = (mode == MODE_NOSPACE) && (pat_rd_q == SPACE_CODE);
	assign miss      = !skip && ((k_q >= seen_q) ||
	                   (fold_byte(win_rd_q, mode) != fold_byte(pat_rd_q, mode)));
	assign k_next    = skip ? k_q : k_q + LEN_W'(1);
	assign last      = (i_q == '0);
	assign found     = !miss && last && (k_next != '0);
	assign slot_free = !out_valid_q || out_pop;

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		pat_we  = 1'b0;
		win_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_entry.op == OP_APPEND && has_room) begin
						pat_we = 1'b1;
					end
					if (q_entry.op == OP_TEXT) begin
						win_we = 1'b1;
					end
					if (q_entry.op == OP_TEXT && len_q != '0) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FETCH: state_d = ST_CHECK;
			ST_CHECK: begin
				if (miss || last) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// memories, read every cycle
	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[len_q[IDX_W-1:0]] <= q_entry.chr;
		end
		if (win_we) begin
			win_mem[head_q] <= q_entry.chr;
		end
		pat_rd_q <= pat_mem[i_q];
		win_rd_q <= win_mem[win_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			seen_q      <= '0;
			head_q      <= '0;
			total_q     <= '0;
			here_q      <= 1'b0;
			full_q      <= 1'b0;
			i_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						here_q <= 1'b0;
						full_q <= (q_entry.op == OP_APPEND) && !has_room;
						k_q    <= '0;
						i_q    <= IDX_W'(len_q - LEN_W'(1));
						case (q_entry.op)
							OP_CLEAR: begin
								len_q   <= '0;
								seen_q  <= '0;
								head_q  <= '0;
								total_q <= '0;
							end
							OP_APPEND: begin
								if (has_room) begin
									len_q <= len_q + LEN_W'(1);
								end
							end
							OP_TEXT: begin
								head_q <= (head_q == IDX_W'(PATTERN_MAX - 1)) ? '0
								                                            : head_q + IDX_W'(1);
								if (seen_q != LEN_W'(PATTERN_MAX)) begin
									seen_q <= seen_q + LEN_W'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHECK: begin
					k_q <= k_next;
					i_q <= i_q - IDX_W'(1);
					if (found) begin
						here_q <= 1'b1;
						if (total_q != '1) begin
							total_q <= total_q + COUNT_BITS'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			out_q.count <= OUT_COUNT_W'(total_q);
			out_q.here  <= here_q;
			out_q.full  <= full_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	// the walk never compares further back than the bytes seen
	a_k_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> k_q <= seen_q)
		else $error("comparison offset ran past the text history");

	// only a clear lowers the running total
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_IDLE && q_valid && q_entry.op == OP_CLEAR)
		|=> total_q >= $past(total_q))
		else $error("occurrence total went down without a clear");

	// a match needs a stored pattern
	a_match_needs_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && here_q |-> len_q != '0)
		else $error("match flagged with an empty pattern");

	// a result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_pop |=> out_valid_q && $stable(out_q))
		else $error("waiting result lost or changed");

	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(PATTERN_MAX) && seen_q <= LEN_W'(PATTERN_MAX))
		else $error("pattern length or history count beyond capacity");

endmodule

`default_nettype wire

// ===== rtl/pattern_occurrence_counter_unit.sv =====
// top level of the pattern occurrence counter: mode register, front queue and back end
`timescale 1ns / 1ps
`default_nettype none

// Counts overlapping occurrences of a stored pattern in a stream of text bytes.
// Items enter through a two-entry queue (push/full) and every item yields one
// result, taken through empty/pop. Clear, append and any item that leaves the
// state alone go straight from idle to the done state in the back end. A text
// byte with a stored pattern first walks from the newest window byte backwards
// through the pattern memory, one pattern byte per read-then-compare pair, and
// stops at the first mismatch or at the first pattern byte. The done state
// waits until the result slot is free. The mode register is to be written
// only while no item is in flight; it takes effect from the next item.

module pattern_occurrence_counter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  char_code,
	output logic             empty,
	input  wire logic        pop,
	output logic [15:0]      match_count,
	output logic             match_here,
	output logic             pattern_full,
	input  wire logic        match_mode_we,
	input  wire logic [1:0]  match_mode_wdata
);
	import poc_pkg::*;

	logic [1:0] mode_q;
	logic       q_valid;
	entry_t     q_entry;
	logic       q_pop;
	logic       out_valid;
	result_t    out_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EXACT;
		end else if (match_mode_we) begin
			mode_q <= match_mode_wdata;
		end
	end

	poc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.char_code (char_code),
		.mode      (mode_q),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	poc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_result (out_result),
		.out_pop    (pop)
	);

	assign empty        = !out_valid;
	assign match_count  = out_result.count;
	assign match_here   = out_result.here;
	assign pattern_full = out_result.full;

endmodule

`default_nettype wire
